[src/tbps_pkg.sv]
// tbps_pkg: types and codes shared by the token bucket packet shaper
// depends on nothing; imported by the output buffer and the top level
package tbps_pkg;

    localparam int LEVEL_W = 10;
    localparam int ID_W    = 16;
    localparam int KIND_W  = 3;

    // request types
    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_PACKET = 1'b1;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_TOKEN_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOKEN_DROPPED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_BIG       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_QUEUED        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUEUE_FULL    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_RELEASED      = 3'd5;

    typedef struct packed {
        logic               req_type;
        logic [ID_W-1:0]    packet_id;
        logic [LEVEL_W-1:0] tokens_needed;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [ID_W-1:0]    event_packet;
        logic [LEVEL_W-1:0] tokens_left;
        logic               last;
    } out_item_t;

    // one waiting packet as stored in the queue memory
    typedef struct packed {
        logic [LEVEL_W-1:0] need;
        logic [ID_W-1:0]    id;
    } queue_entry_t;

    localparam int ENTRY_W = $bits(queue_entry_t);

    // push request from the core into the output buffer
    typedef struct packed {
        logic      push;
        logic      second_valid;
        out_item_t first;
        out_item_t second;
    } out_push_t;

endpackage

[src/tbps_ram.sv]
// tbps_ram: generic single-write, single-read ram with registered read data
// depends on nothing; read data holds when no read is issued
module tbps_ram #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/tbps_out_buf.sv]
// tbps_out_buf: two-entry result buffer in front of the output channel
// depends on tbps_pkg; loaded with one or two beats only when empty
module tbps_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  tbps_pkg::out_push_t push_in,
    output logic                empty,
    output logic                out_valid,
    input  logic                out_ready,
    output tbps_pkg::out_item_t out_data
);
    import tbps_pkg::*;

    logic      v0_reg, v0_next;
    logic      v1_reg, v1_next;
    out_item_t d0_reg, d0_next;
    out_item_t d1_reg, d1_next;

    // load, or shift when the front beat leaves
    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        d0_next = d0_reg;
        d1_next = d1_reg;
        if (push_in.push)
        begin
            v0_next = 1'b1;
            d0_next = push_in.first;
            v1_next = push_in.second_valid;
            d1_next = push_in.second;
        end
        else if (v0_reg && out_ready)
        begin
            if (v1_reg)
            begin
                d0_next = d1_reg;
                v1_next = 1'b0;
            end
            else
            begin
                v0_next = 1'b0;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        d0_reg <= d0_next;
        d1_reg <= d1_next;
    end

    assign empty     = !v0_reg;
    assign out_valid = v0_reg;
    assign out_data  = d0_reg;

endmodule

[src/token_bucket_packet_shaper_core.sv]
// token_bucket_packet_shaper_core: token bucket shaper with a queue of waiting packets
// depends on tbps_pkg, tbps_ram (queue storage) and tbps_out_buf (result beats)
//
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid / in_ready    | in_data   (in_item_t)
//  out     | output    | out_valid / out_ready  | out_data  (out_item_t)
//  cfg     | input     | cfg_wr_en, no wait     | cfg_wr_data (bucket capacity)
//
// an item is handled in ST_IDLE and then ST_CHECK: the accept cycle updates the bucket or queue and
// reads the head entry from the queue ram, and ST_CHECK checks the head for release
// ST_CHECK waits until the result buffer is empty; a new item can be
// taken while earlier result beats still wait on the output
// reset empties the queue, zeroes the bucket and sets capacity to 10; no clearing pass
module token_bucket_packet_shaper_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tbps_pkg::in_item_t       in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tbps_pkg::out_item_t      out_data,
    input  logic                     cfg_wr_en,
    input  logic [9:0]               cfg_wr_data
);
    import tbps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] cap_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               fwd_reg, fwd_next;
    queue_entry_t       fwd_entry_reg;

    logic               accept;
    logic [LEVEL_W-1:0] need_eff;
    queue_entry_t       new_entry;
    logic               do_queue;
    queue_entry_t       head_entry;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic               release_ok;
    logic               buf_empty;
    out_push_t          push;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign need_eff = (in_data.tokens_needed == '0) ? LEVEL_W'(1) : in_data.tokens_needed;
    assign new_entry.need = need_eff;
    assign new_entry.id   = in_data.packet_id;

    // head entry: forwarded when it was written in the accept cycle
    assign head_entry = fwd_reg ? fwd_entry_reg : queue_entry_t'(ram_rd_data);
    assign release_ok = (count_reg != '0) && (level_reg >= head_entry.need);

    // status and release handling
    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        kind_next  = kind_reg;
        id_next    = id_reg;
        fwd_next   = fwd_reg;
        do_queue   = 1'b0;
        push       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fwd_next   = 1'b0;
                    state_next = ST_CHECK;
                    priority if (in_data.req_type == REQ_TICK)
                    begin
                        id_next = '0;
                        if (level_reg >= cap_reg)
                        begin
                            kind_next = KIND_TOKEN_DROPPED;
                        end
                        else
                        begin
                            kind_next  = KIND_TOKEN_ADDED;
                            level_next = level_reg + LEVEL_W'(1);
                        end
                    end
                    else if (need_eff > cap_reg)
                    begin
                        kind_next = KIND_TOO_BIG;
                        id_next   = in_data.packet_id;
                    end
                    else if (count_reg >= FULL_CNT)
                    begin
                        kind_next = KIND_QUEUE_FULL;
                        id_next   = in_data.packet_id;
                    end
                    else
                    begin
                        kind_next  = KIND_QUEUED;
                        id_next    = in_data.packet_id;
                        do_queue   = 1'b1;
                        fwd_next   = (count_reg == '0);
                        tail_next  = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                if (buf_empty)
                begin
                    push.push               = 1'b1;
                    push.first.event_kind   = kind_reg;
                    push.first.event_packet = id_reg;
                    push.first.tokens_left  = level_reg;
                    push.first.last         = !release_ok;
                    push.second_valid       = release_ok;
                    push.second.event_kind   = KIND_RELEASED;
                    push.second.event_packet = head_entry.id;
                    push.second.tokens_left  = level_reg - head_entry.need;
                    push.second.last         = 1'b1;
                    if (release_ok)
                    begin
                        level_next = level_reg - head_entry.need;
                        head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= LEVEL_W'(10);
            level_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fwd_reg   <= fwd_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // status beat payload and forwarded entry
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        if (do_queue)
        begin
            fwd_entry_reg <= new_entry;
        end
    end

    // waiting packet queue
    tbps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (do_queue),
        .wr_addr (tail_reg),
        .wr_data (new_entry),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    // result beats
    tbps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_in   (push),
        .empty     (buf_empty),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
